// ----- rtl/core/dss_pkg.sv -----
// types and constants shared by the descending selection sort
package dss_pkg;

    localparam int MAX_ITEMS_DEF = 16;
    localparam int KEY_W         = 16;
    localparam int TAG_W         = 8;
    localparam int REC_W         = KEY_W + TAG_W;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
    } t_in;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic [TAG_W-1:0] sorted_tag;
        logic             end_of_set;
        logic             dropped;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_rec;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SWAP_A,
        ST_SWAP_B
    } t_state;

endpackage

// ----- rtl/core/descending_selection_sort.sv -----
// Collects up to MAX_ITEMS records (key, tag) one per cycle until a request marked last
// arrives, then sorts them highest key first by selection sort and returns one result per
// record, end_of_set on the final one and dropped on all of them if records past capacity
// were discarded. Records live in one memory with a single read port; each rank scans the
// remaining entries one read per cycle, then swaps in two writes. No new set is taken while
// a sort runs.
module descending_selection_sort #(
    parameter int MAX_ITEMS = dss_pkg::MAX_ITEMS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dss_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dss_pkg::t_out o_out_data
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    dss_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_ovf, n_ovf;
    logic             r_drop, n_drop;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_scan, n_scan;
    logic             r_rd_valid, n_rd_valid;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    dss_pkg::t_rec    r_best, n_best;
    logic [IDX_W-1:0] r_best_idx, n_best_idx;
    dss_pkg::t_rec    r_pos_rec, n_pos_rec;
    logic             r_out_valid, n_out_valid;
    dss_pkg::t_out    r_out, n_out;

    logic             we;
    logic [IDX_W-1:0] waddr;
    dss_pkg::t_rec    wdata;
    dss_pkg::t_rec    rdata;
    logic             in_acc;
    logic             room;
    logic             out_free;

    dss_ram #(
        .WIDTH(dss_pkg::REC_W),
        .DEPTH(MAX_ITEMS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(r_scan[IDX_W-1:0]),
        .o_rdata(rdata)
    );

    assign o_in_ready  = (r_state == dss_pkg::ST_LOAD);
    assign in_acc      = i_in_valid && o_in_ready;
    assign room        = (r_fill < CNT_W'(MAX_ITEMS));
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dss_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_ovf       <= n_ovf;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
        r_drop     <= n_drop;
        r_cnt      <= n_cnt;
        r_pos      <= n_pos;
        r_scan     <= n_scan;
        r_rd_idx   <= n_rd_idx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_pos_rec  <= n_pos_rec;
        r_out      <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_ovf       = r_ovf;
        n_drop      = r_drop;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_scan      = r_scan;
        n_rd_valid  = 1'b0;
        n_rd_idx    = r_scan[IDX_W-1:0];
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_pos_rec   = r_pos_rec;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = r_fill[IDX_W-1:0];
        wdata       = '{key: i_in_data.key, tag: i_in_data.tag};

        case (r_state)
            dss_pkg::ST_LOAD: begin
                if (in_acc) begin
                    we = room;
                    if (room) begin
                        n_fill = r_fill + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last) begin
                        n_cnt   = room ? r_fill + CNT_W'(1) : r_fill;
                        n_drop  = r_ovf || !room;
                        n_fill  = '0;
                        n_ovf   = 1'b0;
                        n_pos   = '0;
                        n_scan  = '0;
                        n_state = dss_pkg::ST_SCAN;
                    end
                end
            end
            dss_pkg::ST_SCAN: begin
                // one read per cycle, registered read data compared when it returns
                if (r_scan < r_cnt) begin
                    n_rd_valid = 1'b1;
                    n_scan     = r_scan + CNT_W'(1);
                end
                if (r_rd_valid) begin
                    if (r_rd_idx == r_pos) begin
                        n_pos_rec  = rdata;
                        n_best     = rdata;
                        n_best_idx = r_rd_idx;
                    end else if (rdata.key > r_best.key) begin
                        n_best     = rdata;
                        n_best_idx = r_rd_idx;
                    end
                    if (CNT_W'(r_rd_idx) + CNT_W'(1) == r_cnt) begin
                        n_state = dss_pkg::ST_SWAP_A;
                    end
                end
            end
            dss_pkg::ST_SWAP_A: begin
                we      = 1'b1;
                waddr   = r_best_idx;
                wdata   = r_pos_rec;
                n_state = dss_pkg::ST_SWAP_B;
            end
            dss_pkg::ST_SWAP_B: begin
                if (out_free) begin
                    we                 = 1'b1;
                    waddr              = r_pos;
                    wdata              = r_best;
                    n_out_valid        = 1'b1;
                    n_out.sorted_key   = r_best.key;
                    n_out.sorted_tag   = r_best.tag;
                    n_out.end_of_set   = (CNT_W'(r_pos) + CNT_W'(1) == r_cnt);
                    n_out.dropped      = r_drop;
                    if (CNT_W'(r_pos) + CNT_W'(1) == r_cnt) begin
                        n_state = dss_pkg::ST_LOAD;
                    end else begin
                        n_pos   = r_pos + IDX_W'(1);
                        n_scan  = CNT_W'(r_pos) + CNT_W'(1);
                        n_state = dss_pkg::ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = dss_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// ----- rtl/core/dss_ram.sv -----
// generic single write port ram with registered read
module dss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/dss_checker.sv -----
// port level checks for the descending selection sort, bound to the top level
module dss_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input dss_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input dss_pkg::t_out o_out_data
);

    logic                      out_acc;
    logic                      r_in_run;
    logic [dss_pkg::KEY_W-1:0] r_prev_key;
    logic                      r_prev_drop;

    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
        end else if (out_acc) begin
            r_in_run <= !o_out_data.end_of_set;
        end
        if (out_acc) begin
            r_prev_key  <= o_out_data.sorted_key;
            r_prev_drop <= o_out_data.dropped;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // keys never rise within a run
    a_descending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_in_run |-> o_out_data.sorted_key <= r_prev_key)
        else $error("sorted run not descending");

    // dropped flag is the same on every result of a run
    a_drop_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_in_run |-> o_out_data.dropped == r_prev_drop)
        else $error("dropped flag changed within run");

    // ready drops after a request marked last is taken
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.last |=> !o_in_ready)
        else $error("request taken during sort");

endmodule

bind descending_selection_sort dss_checker u_dss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
